FILE: rtl/swm_pkg.sv
// Shared widths, register codes and cell link types for the sliding window median filter.
`default_nettype none

package swm_pkg;

  // Window geometry and field widths.
  localparam int unsigned MAX_WINDOW = 64;
  localparam int unsigned IDX_W      = $clog2(MAX_WINDOW);
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned APB_AW     = 3;

  // Register index as seen on the word address bit of the configuration port.
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  // Reset value of the window_length register.
  localparam logic [LEN_W-1:0] WINDOW_LENGTH_RST = LEN_W'(MAX_WINDOW);

  // What one cell hands to its right neighbor: its entry after the
  // outgoing sample is removed, and whether that entry sorts at or
  // below the incoming sample.
  typedef struct packed {
    logic signed [DATA_W-1:0] key;
    logic                     le;
  } rem_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                     upd;
    logic                     clr;
    logic signed [DATA_W-1:0] old_key;
    logic signed [DATA_W-1:0] new_key;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/swm_cell.sv
// One cell of the sorted chain: holds one ordered entry and moves it on remove and insert.
`default_nettype none

module swm_cell (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire swm_pkg::cell_ctrl_t                ctrl,
  input  wire logic                               active,
  input  wire logic                               last,
  input  wire swm_pkg::rem_t                      left,
  input  wire logic signed [swm_pkg::DATA_W-1:0]  right_key,
  output logic signed [swm_pkg::DATA_W-1:0]       key,
  output swm_pkg::rem_t                           rem
);

  logic signed [swm_pkg::DATA_W-1:0] key_r;
  logic signed [swm_pkg::DATA_W-1:0] key_nxt;
  logic signed [swm_pkg::DATA_W-1:0] fill;
  logic                              lt_old;

  // Removal: entries from the outgoing sample onward take the right neighbor.
  always_comb begin
    lt_old  = key_r < ctrl.old_key;
    rem.key = lt_old ? key_r : right_key;
    rem.le  = !last && (rem.key <= ctrl.new_key);
  end

  // Insertion: keep entries at or below the new word, place the new word
  // right after them, and shift the rest one cell to the right.
  always_comb begin
    if (rem.le) begin
      fill = rem.key;
    end else if (left.le) begin
      fill = ctrl.new_key;
    end else begin
      fill = left.key;
    end
  end

  always_comb begin
    key_nxt = key_r;
    if (ctrl.clr) begin
      key_nxt = '0;
    end else if (ctrl.upd && active) begin
      key_nxt = fill;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  assign key = key_r;

endmodule

`default_nettype wire

FILE: rtl/swm_window.sv
// Circular sample store with per-entry valid bits and a registered read of the oldest word.
`default_nettype none

module swm_window (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               clr,
  input  wire logic                               we,
  input  wire logic [swm_pkg::IDX_W-1:0]          addr,
  input  wire logic signed [swm_pkg::DATA_W-1:0]  wdata,
  output logic signed [swm_pkg::DATA_W-1:0]       rdata
);

  logic signed [swm_pkg::DATA_W-1:0] mem [swm_pkg::MAX_WINDOW];
  logic signed [swm_pkg::DATA_W-1:0] rd_r;
  logic [swm_pkg::MAX_WINDOW-1:0]    vld_r;
  logic [swm_pkg::MAX_WINDOW-1:0]    vld_nxt;
  logic                              rd_vld_r;

  // Read the entry being replaced, then overwrite it.
  always_ff @(posedge clk) begin
    if (we) begin
      rd_r       <= mem[addr];
      mem[addr]  <= wdata;
    end
  end

  // Valid bits: an entry never written since reset or a clear reads as zero.
  always_comb begin
    vld_nxt = vld_r;
    if (clr) begin
      vld_nxt = '0;
    end else if (we) begin
      vld_nxt[addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (we) begin
        rd_vld_r <= vld_r[addr];
      end
    end
  end

  assign rdata = rd_vld_r ? rd_r : '0;

endmodule

`default_nettype wire

FILE: rtl/sliding_window_median_top.sv
// Top level of the sliding window median filter: control, configuration and the cell chain.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_sample (32b signed Q16.16)
//   out      output     out_valid/out_ready  out_median (32b signed Q16.16)
//   cfg      input      APB psel/penable     cfg_pwdata[6:0] window_length at 0x0
//
// For each word the sample store is read and written, the cell chain
// removes the oldest word and inserts the new one in one step, and the
// median cell is copied into the output register.
// The next word is accepted once that copy is made, even while the result waits.
// A stalled output holds the result state until the result register frees up.
// Reset and a window_length write clear the chain and the store at once.
`default_nettype none

module sliding_window_median_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [swm_pkg::DATA_W-1:0]   in_sample,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [swm_pkg::DATA_W-1:0]        out_median,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [swm_pkg::APB_AW-1:0]          cfg_paddr,
  input  wire logic [swm_pkg::APB_DW-1:0]          cfg_pwdata,
  output logic [swm_pkg::APB_DW-1:0]               cfg_prdata,
  output logic                                     cfg_pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_RES
  } state_t;

  state_t                            state_r;
  logic [swm_pkg::LEN_W-1:0]         wl_r;
  logic [swm_pkg::LEN_W-1:0]         n_len;
  logic [swm_pkg::IDX_W-1:0]         pos_r;
  logic [swm_pkg::IDX_W-1:0]         pos_nxt;
  logic [swm_pkg::IDX_W-1:0]         half;
  logic signed [swm_pkg::DATA_W-1:0] new_r;
  logic signed [swm_pkg::DATA_W-1:0] old_key;
  logic signed [swm_pkg::DATA_W-1:0] out_median_r;
  logic                              out_valid_r;
  logic                              in_acc;
  logic                              cfg_wr;
  logic                              res_load;
  swm_pkg::cell_ctrl_t               ctrl;
  logic signed [swm_pkg::DATA_W-1:0] key_w [swm_pkg::MAX_WINDOW];
  swm_pkg::rem_t                     rem_w [swm_pkg::MAX_WINDOW];

  // Handshakes.
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite
                    && (cfg_paddr[swm_pkg::APB_AW-1] == swm_pkg::REG_WINDOW_LENGTH);
  assign res_load = (state_r == S_RES) && (!out_valid_r || out_ready);

  // Configuration read back.
  assign cfg_pready = 1'b1;
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[swm_pkg::APB_AW-1] == swm_pkg::REG_WINDOW_LENGTH) begin
      cfg_prdata = swm_pkg::APB_DW'(wl_r);
    end
  end

  // Effective window length: zero acts as one, anything above the maximum as the maximum.
  always_comb begin
    if (wl_r == '0) begin
      n_len = swm_pkg::LEN_W'(1);
    end else if (wl_r > swm_pkg::LEN_W'(swm_pkg::MAX_WINDOW)) begin
      n_len = swm_pkg::LEN_W'(swm_pkg::MAX_WINDOW);
    end else begin
      n_len = wl_r;
    end
  end

  assign half = n_len[swm_pkg::LEN_W-1:1];

  // Write position wraps at the window length.
  always_comb begin
    if (swm_pkg::LEN_W'(pos_r) == n_len - swm_pkg::LEN_W'(1)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + swm_pkg::IDX_W'(1);
    end
  end

  // Sample store: yields the outgoing word in the cycle after acceptance.
  swm_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (cfg_wr),
    .we    (in_acc),
    .addr  (pos_r),
    .wdata (in_sample),
    .rdata (old_key)
  );

  // Broadcast to the chain.
  always_comb begin
    ctrl.upd     = (state_r == S_UPD);
    ctrl.clr     = cfg_wr;
    ctrl.old_key = old_key;
    ctrl.new_key = new_r;
  end

  // Sorted chain of cells, ascending from cell zero.
  for (genvar gi = 0; gi < swm_pkg::MAX_WINDOW; gi++) begin : g_cell
    swm_pkg::rem_t                     left;
    logic signed [swm_pkg::DATA_W-1:0] right_key;

    if (gi == 0) begin : g_first
      assign left = '{key: '0, le: 1'b1};
    end else begin : g_mid
      assign left = rem_w[gi-1];
    end

    if (gi == swm_pkg::MAX_WINDOW - 1) begin : g_end
      assign right_key = '0;
    end else begin : g_inner
      assign right_key = key_w[gi+1];
    end

    swm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .active    (swm_pkg::LEN_W'(gi) < n_len),
      .last      (swm_pkg::LEN_W'(gi) == n_len - swm_pkg::LEN_W'(1)),
      .left      (left),
      .right_key (right_key),
      .key       (key_w[gi]),
      .rem       (rem_w[gi])
    );
  end

  // Control state, configuration register and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wl_r        <= swm_pkg::WINDOW_LENGTH_RST;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        wl_r  <= cfg_pwdata[swm_pkg::LEN_W-1:0];
        pos_r <= '0;
      end else if (in_acc) begin
        pos_r <= pos_nxt;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          state_r <= S_RES;
        end
        S_RES: begin
          if (res_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (res_load) begin
        out_valid_r  <= 1'b1;
        out_median_r <= key_w[half];
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload register for the word in flight.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      new_r <= in_sample;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;

`ifndef SYNTHESIS
  // An accepted word always goes straight to the chain update.
  a_acc_upd: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_UPD))
    else $error("accepted word did not reach the chain update");

  // A new result only appears from the result cycle.
  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_RES))
    else $error("result raised outside the result cycle");

  // The write position stays inside the window.
  a_pos_rng: assert property (@(posedge clk) disable iff (!rst_n)
    (swm_pkg::LEN_W'(pos_r) < n_len))
    else $error("write position outside the window");

  // Cell zero never holds more than the median cell.
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (key_w[0] <= key_w[half]))
    else $error("cell chain out of order");

  // A pending result is not overwritten while stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_median_r)))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_sliding_window_median_top.sv
// Self-checking testbench for the sliding window median filter with random traffic and stalls.
`default_nettype none

module tb_sliding_window_median_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [swm_pkg::APB_AW-1:0] WLEN_ADDR = {swm_pkg::REG_WINDOW_LENGTH, 2'b00};
  localparam logic signed [swm_pkg::DATA_W-1:0] SAMPLE_MAX =
    {1'b0, {(swm_pkg::DATA_W-1){1'b1}}};
  localparam logic signed [swm_pkg::DATA_W-1:0] SAMPLE_MIN =
    {1'b1, {(swm_pkg::DATA_W-1){1'b0}}};
  localparam int unsigned              LONG_HOLD  = 300;
  localparam int unsigned              IDLE_LIMIT = 4000;
  localparam int unsigned              PHASE_WORDS = 150;
  localparam int unsigned              PAD_W = swm_pkg::APB_DW - swm_pkg::LEN_W;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic signed [swm_pkg::DATA_W-1:0]   in_sample = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [swm_pkg::DATA_W-1:0]   out_median;
  logic                                cfg_psel = 1'b0;
  logic                                cfg_penable = 1'b0;
  logic                                cfg_pwrite = 1'b0;
  logic [swm_pkg::APB_AW-1:0]          cfg_paddr = '0;
  logic [swm_pkg::APB_DW-1:0]          cfg_pwdata = '0;
  logic [swm_pkg::APB_DW-1:0]          cfg_prdata;
  logic                                cfg_pready;

  // Words waiting to be sent and medians waiting to come back.
  logic signed [swm_pkg::DATA_W-1:0]   sample_pending_q[$];
  logic signed [swm_pkg::DATA_W-1:0]   median_expect_q[$];

  // Shadow of the block: circular window, write position and length register.
  logic signed [swm_pkg::DATA_W-1:0]   win_store [swm_pkg::MAX_WINDOW];
  logic [swm_pkg::LEN_W-1:0]           win_len;
  int unsigned                         win_head;

  int unsigned                mismatches = 0;
  logic                       in_word_taken = 1'b0;
  int unsigned                send_gap = 0;
  int unsigned                recv_gap = 0;
  int unsigned                hold_left = 0;
  int unsigned                hold_req = 0;
  int unsigned                hold_seen = 0;
  int unsigned                idle_cycles = 0;

  sliding_window_median_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_median  (out_median),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lengths of 0 and above the store depth fold back into the legal range.
  function automatic int unsigned active_length();
    if (win_len == '0) return 1;
    if (win_len > swm_pkg::MAX_WINDOW) return swm_pkg::MAX_WINDOW;
    return win_len;
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < swm_pkg::MAX_WINDOW; i++) win_store[i] = '0;
    win_head = 0;
  endfunction

  // Replace the oldest sample and return the element of rank n/2 of the window.
  function automatic logic signed [swm_pkg::DATA_W-1:0] take_sample(
      input logic signed [swm_pkg::DATA_W-1:0] smp);
    logic signed [swm_pkg::DATA_W-1:0] ranked [swm_pkg::MAX_WINDOW];
    logic signed [swm_pkg::DATA_W-1:0] key;
    int unsigned                       n;
    int unsigned                       pos;
    int                                j;
    n = active_length();
    pos = (win_head >= n) ? 0 : win_head;
    win_store[pos] = smp;
    for (int i = 0; i < n; i++) begin
      key = win_store[i];
      j = i;
      while (j > 0 && ranked[j-1] > key) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = key;
    end
    pos++;
    win_head = (pos >= n) ? 0 : pos;
    return ranked[n/2];
  endfunction

  // Mostly no idle gap, some short ones, a few long.
  function automatic int unsigned pick_idle();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 11) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Full-range values, a narrow band that forces duplicates, extremes and whole numbers.
  function automatic logic signed [swm_pkg::DATA_W-1:0] random_sample();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return $urandom();
    if (roll < 8) return int'($urandom_range(0, 16)) - 8;
    if (roll == 8) begin
      case ($urandom_range(0, 3))
        0: return SAMPLE_MAX;
        1: return SAMPLE_MIN;
        2: return -1;
        default: return 0;
      endcase
    end
    return (int'($urandom_range(0, 200)) - 100) <<< 16;
  endfunction

  // Sender: a new word after each accepted one, once its gap has run out.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_word_taken) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (sample_pending_q.size() > 0) begin
        in_valid  <= 1'b1;
        in_sample <= sample_pending_q.pop_front();
        send_gap  <= pick_idle();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      out_ready <= 1'b0;
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
    end else if (recv_gap > 0) begin
      out_ready <= 1'b0;
      recv_gap  <= recv_gap - 1;
    end else begin
      out_ready <= 1'b1;
      recv_gap  <= pick_idle();
    end
  end

  // Monitor: check each median word, then predict from each accepted sample.
  always @(posedge clk) begin : median_check
    logic signed [swm_pkg::DATA_W-1:0] want;
    in_word_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (median_expect_q.size() == 0) begin
          $error("median word %0d arrived with none expected", out_median);
          mismatches++;
        end else begin
          want = median_expect_q.pop_front();
          if (out_median !== want) begin
            $error("median mismatch: expected %0d, actual %0d", want, out_median);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) median_expect_q.push_back(take_sample(in_sample));
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_psel && cfg_penable && cfg_pready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Wait until every queued word has gone in and every median has come out.
  task automatic wait_idle();
    do @(posedge clk);
    while (sample_pending_q.size() != 0 || in_valid || median_expect_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window_length(input logic [swm_pkg::APB_DW-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= WLEN_ADDR;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    win_len = value[swm_pkg::LEN_W-1:0];
    clear_window();
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic check_window_length();
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= WLEN_ADDR;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    if (cfg_prdata !== swm_pkg::APB_DW'(win_len)) begin
      $error("window_length mismatch: expected %0d, actual %0d", win_len, cfg_prdata);
      mismatches++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Stimulus: directed corners, then random phases over a range of window lengths.
  initial begin
    int unsigned                 phase_len [13];
    logic [swm_pkg::APB_DW-1:0]  wr_value;
    win_len = swm_pkg::WINDOW_LENGTH_RST;
    clear_window();
    phase_len = '{2, 3, 64, 7, 127, 16, 1, 33, 63, 0, 100, 5, 64};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset length: the window starts full of zeros.
    check_window_length();
    sample_pending_q = '{SAMPLE_MAX, SAMPLE_MIN, -1, 1, 32'sh0001_0000, 32'shFFFF_0000,
                         32'sh5555_5555, 32'shAAAA_AAAA, SAMPLE_MAX, SAMPLE_MAX};
    wait_idle();

    // Window of one: the median follows the input.
    write_window_length(1);
    sample_pending_q = '{SAMPLE_MAX, SAMPLE_MIN, 0};
    wait_idle();

    // Length zero acts as one.
    write_window_length(0);
    check_window_length();
    sample_pending_q = '{-1, SAMPLE_MAX, 7};
    wait_idle();

    // Even length takes the upper median; equal words leave the window in turn.
    write_window_length(2);
    sample_pending_q = '{SAMPLE_MIN, SAMPLE_MAX, 5, 5, -5};
    wait_idle();

    // Oversized length acts as the full store depth.
    write_window_length(127);
    check_window_length();
    sample_pending_q = '{SAMPLE_MIN, 3, -3, SAMPLE_MAX};
    wait_idle();

    // Random phases; each waits for every median before the length changes.
    foreach (phase_len[p]) begin
      wr_value = swm_pkg::APB_DW'(phase_len[p]);
      if (p % 2 == 1) wr_value[swm_pkg::APB_DW-1:swm_pkg::LEN_W] = PAD_W'($urandom());
      write_window_length(wr_value);
      check_window_length();
      repeat (PHASE_WORDS) sample_pending_q.push_back(random_sample());
      if (p == 2 || p == 8) begin
        @(posedge clk);
        hold_req++;
      end
      wait_idle();
    end

    // A random length to finish with.
    write_window_length($urandom_range(0, 127));
    check_window_length();
    repeat (PHASE_WORDS) sample_pending_q.push_back(random_sample());
    wait_idle();

    repeat (20) @(posedge clk);
    if (median_expect_q.size() != 0) begin
      $error("%0d median words never arrived", median_expect_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
